@@ hw/rtl/ccfd_pkg.sv @@
package ccfd_pkg;

    // Control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ESC = 8'h1B;

    localparam logic [7:0] ESC_OFFSET_RST = 8'd32;

    localparam int MAX_FIELD_BYTES = 1024;
    localparam int IDX_W = 10;
    localparam int IDX_MAX = (1 << IDX_W) - 1;
    localparam int IDX_CAP_INT = (MAX_FIELD_BYTES - 1) < IDX_MAX ? (MAX_FIELD_BYTES - 1) : IDX_MAX;
    localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_CAP_INT);

    // Region codes
    localparam logic [1:0] REG_IDLE = 2'd0;
    localparam logic [1:0] REG_HDR  = 2'd1;
    localparam logic [1:0] REG_BODY = 2'd2;
    localparam logic [1:0] REG_TAIL = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Frame status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NO_SOH = 3'd1;
    localparam logic [2:0] ST_NO_STX = 3'd2;
    localparam logic [2:0] ST_NO_ETX = 3'd3;
    localparam logic [2:0] ST_NO_EOT = 3'd4;
    localparam logic [2:0] ST_ORDER  = 3'd5;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [1:0]       out_kind;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic [2:0]       frame_status;
        logic             last_result;
    } t_out;

    typedef struct packed {
        logic vld_a;
        logic vld_b;
    } t_push;

endpackage

@@ hw/rtl/ccfd_core.sv @@
module ccfd_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ccfd_pkg::t_in  i_in_data,
    input  logic           i_cfg_valid,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_room,
    output ccfd_pkg::t_push o_push,
    output ccfd_pkg::t_out o_res_a,
    output ccfd_pkg::t_out o_res_b,
    output logic           o_consume
);
    import ccfd_pkg::*;

    logic             r_in_vld;
    t_in              r_in;
    logic [7:0]       r_esc_off;
    logic [1:0]       r_region,   n_region;
    logic             r_seen_soh, n_seen_soh;
    logic             r_seen_stx, n_seen_stx;
    logic             r_seen_etx, n_seen_etx;
    logic             r_seen_eot, n_seen_eot;
    logic             r_order,    n_order;
    logic             r_esc,      n_esc;
    logic [IDX_W-1:0] r_count,    n_count;

    logic       consume;
    logic       d_vld;
    t_out       d_res;
    t_out       s_res;
    logic [7:0] b;
    logic [2:0] st;

    assign consume    = r_in_vld && i_room;
    assign o_in_ready = !r_in_vld || consume;
    assign o_consume  = consume;
    assign b          = r_in.rx_byte;

    always_comb begin
        n_region   = r_region;
        n_seen_soh = r_seen_soh;
        n_seen_stx = r_seen_stx;
        n_seen_etx = r_seen_etx;
        n_seen_eot = r_seen_eot;
        n_order    = r_order;
        n_esc      = r_esc;
        n_count    = r_count;
        d_vld      = 1'b0;
        d_res      = '0;
        st         = ST_OK;

        // Only the first copy of each marker is a boundary
        priority if (b == CH_SOH && !r_seen_soh) begin
            n_seen_soh = 1'b1;
            if (r_seen_stx || r_seen_etx || r_seen_eot) n_order = 1'b1;
            if (r_region == REG_IDLE) begin
                n_region = REG_HDR;
                n_esc    = 1'b0;
                n_count  = '0;
            end
        end else if (b == CH_STX && !r_seen_stx) begin
            n_seen_stx = 1'b1;
            if (!r_seen_soh || r_seen_etx || r_seen_eot) n_order = 1'b1;
            if (r_region == REG_HDR) begin
                n_region = REG_BODY;
                n_esc    = 1'b0;
                n_count  = '0;
            end
        end else if (b == CH_ETX && !r_seen_etx) begin
            n_seen_etx = 1'b1;
            if (!r_seen_stx || r_seen_eot) n_order = 1'b1;
            if (r_region == REG_BODY) begin
                n_region = REG_TAIL;
                n_esc    = 1'b0;
            end
        end else if (b == CH_EOT && !r_seen_eot) begin
            n_seen_eot = 1'b1;
            if (!r_seen_etx) n_order = 1'b1;
        end else if (r_region == REG_HDR || r_region == REG_BODY) begin
            if (b == CH_ESC) begin
                n_esc = 1'b1;
            end else begin
                d_vld            = 1'b1;
                d_res.out_kind   = (r_region == REG_HDR) ? KIND_HEADER : KIND_BODY;
                d_res.data_byte  = r_esc ? (b - r_esc_off) : b;
                d_res.byte_index = r_count;
                n_esc            = 1'b0;
                if (r_count < IDX_CAP) n_count = r_count + 1'b1;
            end
        end else begin
            // Drop bytes outside header and body
        end

        priority if (!n_seen_soh) st = ST_NO_SOH;
        else if (!n_seen_stx)     st = ST_NO_STX;
        else if (!n_seen_etx)     st = ST_NO_ETX;
        else if (!n_seen_eot)     st = ST_NO_EOT;
        else if (n_order)         st = ST_ORDER;
        else                      st = ST_OK;

        // End of message: back to reset
        if (r_in.end_of_message) begin
            n_region   = REG_IDLE;
            n_seen_soh = 1'b0;
            n_seen_stx = 1'b0;
            n_seen_etx = 1'b0;
            n_seen_eot = 1'b0;
            n_order    = 1'b0;
            n_esc      = 1'b0;
            n_count    = '0;
        end
    end

    always_comb begin
        s_res              = '0;
        s_res.out_kind     = KIND_STATUS;
        s_res.frame_status = st;
        s_res.last_result  = 1'b1;
    end

    // Data result first, status after it
    assign o_res_a      = d_vld ? d_res : s_res;
    assign o_res_b      = s_res;
    assign o_push.vld_a = consume && (d_vld || r_in.end_of_message);
    assign o_push.vld_b = consume && d_vld && r_in.end_of_message;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_esc_off  <= ESC_OFFSET_RST;
            r_region   <= REG_IDLE;
            r_seen_soh <= 1'b0;
            r_seen_stx <= 1'b0;
            r_seen_etx <= 1'b0;
            r_seen_eot <= 1'b0;
            r_order    <= 1'b0;
            r_esc      <= 1'b0;
            r_count    <= '0;
        end else begin
            if (o_in_ready) r_in_vld <= i_in_valid;
            if (i_cfg_valid) r_esc_off <= i_cfg_data;
            if (consume) begin
                r_region   <= n_region;
                r_seen_soh <= n_seen_soh;
                r_seen_stx <= n_seen_stx;
                r_seen_etx <= n_seen_etx;
                r_seen_eot <= n_seen_eot;
                r_order    <= n_order;
                r_esc      <= n_esc;
                r_count    <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in <= i_in_data;
    end

endmodule

@@ hw/rtl/ccfd_rq.sv @@
module ccfd_rq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ccfd_pkg::t_push i_push,
    input  ccfd_pkg::t_out  i_res_a,
    input  ccfd_pkg::t_out  i_res_b,
    output logic            o_room,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ccfd_pkg::t_out  o_out_data
);
    import ccfd_pkg::*;

    t_out                r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wr, n_wr;
    logic [RQ_PTR_W-1:0] r_rd;
    logic [RQ_CNT_W-1:0] r_cnt, n_cnt;
    logic [RQ_PTR_W-1:0] wr_b;
    logic                pop;

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_mem[r_rd];
    // Leave space for a transaction that makes two results
    assign o_room      = (r_cnt <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign wr_b        = r_wr + 1'b1;

    always_comb begin
        n_wr  = r_wr + RQ_PTR_W'(i_push.vld_a) + RQ_PTR_W'(i_push.vld_b);
        n_cnt = r_cnt + RQ_CNT_W'(i_push.vld_a) + RQ_CNT_W'(i_push.vld_b) - RQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
            if (pop) r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld_a) r_mem[r_wr] <= i_res_a;
        if (i_push.vld_b) r_mem[wr_b] <= i_res_b;
    end

endmodule

@@ hw/rtl/control_char_frame_decoder.sv @@
// Decodes SOH/STX/ETX/EOT framed messages one received byte per cycle while the result
// queue has room. Header bytes (between SOH and STX) and body bytes (between STX and
// ETX) come out with their position; ESC is dropped and the next byte comes out minus
// the escape offset. The byte flagged end_of_message also yields a status result
// (last_result = 1), after any data result of that byte; discard the data when the
// status is not ok. Each byte passes an input register and a 4-entry result queue
// before its result can be taken. The decoder takes one byte per cycle while the queue
// has room; a final byte that also carries data makes two results, and the single output
// port drains one result per cycle when ready; sustained throughput is set by that port.
module control_char_frame_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ccfd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ccfd_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);
    import ccfd_pkg::*;

    t_push push;
    t_out  res_a;
    t_out  res_b;
    logic  room;
    logic  consume;

    assign o_cfg_ready = 1'b1;

    ccfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push),
        .o_res_a     (res_a),
        .o_res_b     (res_b),
        .o_consume   (consume)
    );

    ccfd_rq u_rq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res_a     (res_a),
        .i_res_b     (res_b),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_push_needs_consume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.vld_a || push.vld_b) |-> consume)
        else $error("result pushed without a consumed transaction");

    a_second_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.vld_b |-> (push.vld_a && res_a.out_kind != KIND_STATUS))
        else $error("second result without a leading data result");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_result == (o_out_data.out_kind == KIND_STATUS)))
        else $error("last_result disagrees with out_kind");

    a_data_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_kind != KIND_STATUS) |->
        (o_out_data.frame_status == ST_OK))
        else $error("data result carries a status");

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
